[rtl/core/bdms_pkg.sv]
// ----------------------------------------------------------------------------
// bdms_pkg
// Shared types and constants for the button debounce and mode select block.
// ----------------------------------------------------------------------------
package bdms_pkg;

  localparam int unsigned CMD_BUTTONS = 3;
  localparam int unsigned TH_W        = 10;
  localparam int unsigned LOCK_W      = 21;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [TH_W-1:0]   PRESS_TH_RST   = 10'd500;
  localparam logic [TH_W-1:0]   RELEASE_TH_RST = 10'd200;
  localparam logic [LOCK_W-1:0] LOCKOUT_RST    = 21'd2000000;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT    = 2'd2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LOCK_W-1:0] lock_t;
  typedef logic [TH_W-1:0]   th_t;

endpackage

[rtl/core/button_debounce_mode_select.sv]
// ----------------------------------------------------------------------------
// button_debounce_mode_select
// Counter based debouncer for a set of buttons with mode command issue on
// the first three buttons (record, track, idle) and a per-button lockout.
//
// Usage:
//   in channel  : one item per tick, in_raw_buttons holds the raw levels
//   out channel : one item per input item, out_mode_commands holds the
//                 commands issued on that tick, out_debounced_buttons the
//                 press latches after it
//   cfg channel : press/release threshold and lockout register writes, always
//                 ready; the user writes while the block idles (not enforced)
// Flow: the input register takes the item, then the debounce update writes
// the state and the output register together once the output register is
// free or read. Throughput is one item per cycle while out_ready stays high.
// When the receiver stalls, the output register holds its item and the
// input register fills; in_ready then drops until out_ready returns.
// Reset clears the counters, latches and pending flags and loads the
// register defaults (500, 200, 2000000).
// ----------------------------------------------------------------------------
module button_debounce_mode_select #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [NUM_BUTTONS-1:0]              in_raw_buttons,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_mode_commands,
  output logic [NUM_BUTTONS-1:0]              out_debounced_buttons,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdms_pkg::LOCK_W-1:0]         cfg_data
);

  localparam int NCMD = (NUM_BUTTONS < int'(bdms_pkg::CMD_BUTTONS)) ?
                        NUM_BUTTONS : int'(bdms_pkg::CMD_BUTTONS);

  bdms_pkg::th_t   press_th_r, release_th_r;
  bdms_pkg::lock_t lockout_ticks_r;

  logic                   s1_valid_r;
  logic [NUM_BUTTONS-1:0] s1_raw_r;
  logic                   adv;

  bdms_pkg::cnt_t         cnt_r   [NUM_BUTTONS];
  bdms_pkg::cnt_t         cnt_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] rp_r, rp_nxt;
  logic [NUM_BUTTONS-1:0] pp_r, pp_nxt;
  logic [NUM_BUTTONS-1:0] latch_r, latch_nxt;
  bdms_pkg::lock_t        lock_r   [bdms_pkg::CMD_BUTTONS];
  bdms_pkg::lock_t        lock_nxt [bdms_pkg::CMD_BUTTONS];
  logic [2:0]             cmd_nxt;

  logic                   out_valid_r;
  logic [2:0]             out_cmd_r;
  logic [NUM_BUTTONS-1:0] out_deb_r;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  assign out_valid             = out_valid_r;
  assign out_mode_commands     = out_cmd_r;
  assign out_debounced_buttons = out_deb_r;

  // lockout countdown, command issue, then debounce
  always_comb begin
    logic [NUM_BUTTONS-1:0] lt;
    logic                   lvl, dp, dr, rp, pp;
    bdms_pkg::cnt_t         c;
    lt      = latch_r;
    cmd_nxt = '0;
    for (int i = 0; i < int'(bdms_pkg::CMD_BUTTONS); i++) begin
      lock_nxt[i] = '0;
      if (i < NCMD) begin
        lock_nxt[i] = (lock_r[i] != '0) ? lock_r[i] - 1'b1 : lock_r[i];
        if (lt[i] && lock_nxt[i] == '0) begin
          cmd_nxt[i]  = 1'b1;
          lt[i]       = 1'b0;
          lock_nxt[i] = lockout_ticks_r;
        end
      end
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      lvl = s1_raw_r[i];
      dp  = lvl && !lt[i];
      dr  = !lvl && lt[i];
      rp  = rp_r[i];
      pp  = pp_r[i];
      c   = cnt_r[i];
      if (lvl == lt[i]) begin
        c  = '0;
        rp = 1'b0;
        pp = 1'b0;
      end else begin
        if (!rp && !pp) begin
          rp = dr;
          pp = dp;
        end
        if (((rp && dr) || (pp && dp)) && c != bdms_pkg::CNT_MAX)
          c = c + 1'b1;
        if ((rp && dp) || (pp && dr)) begin
          c  = '0;
          rp = 1'b0;
          pp = 1'b0;
        end
        if (pp && c > {1'b0, press_th_r}) begin
          c     = '0;
          rp    = 1'b0;
          pp    = 1'b0;
          lt[i] = 1'b1;
        end
        if (rp && c > {1'b0, release_th_r}) begin
          c     = '0;
          rp    = 1'b0;
          pp    = 1'b0;
          lt[i] = 1'b0;
        end
      end
      cnt_nxt[i] = c;
      rp_nxt[i]  = rp;
      pp_nxt[i]  = pp;
    end
    latch_nxt = lt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_th_r      <= bdms_pkg::PRESS_TH_RST;
      release_th_r    <= bdms_pkg::RELEASE_TH_RST;
      lockout_ticks_r <= bdms_pkg::LOCKOUT_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      rp_r            <= '0;
      pp_r            <= '0;
      latch_r         <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++)
        cnt_r[i] <= '0;
      for (int i = 0; i < int'(bdms_pkg::CMD_BUTTONS); i++)
        lock_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdms_pkg::REG_PRESS_TH:   press_th_r      <= cfg_data[bdms_pkg::TH_W-1:0];
          bdms_pkg::REG_RELEASE_TH: release_th_r    <= cfg_data[bdms_pkg::TH_W-1:0];
          bdms_pkg::REG_LOCKOUT:    lockout_ticks_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
        s1_raw_r   <= in_raw_buttons;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        out_cmd_r   <= cmd_nxt;
        out_deb_r   <= latch_nxt;
        rp_r        <= rp_nxt;
        pp_r        <= pp_nxt;
        latch_r     <= latch_nxt;
        for (int i = 0; i < NUM_BUTTONS; i++)
          cnt_r[i] <= cnt_nxt[i];
        for (int i = 0; i < int'(bdms_pkg::CMD_BUTTONS); i++)
          lock_r[i] <= lock_nxt[i];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a command reloads its lockout, none issues while locked, one run direction
  generate
    for (genvar g = 0; g < NCMD; g++) begin : g_cmd_chk
      a_cmd_reload: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cmd_nxt[g] |=> lock_r[g] == $past(lockout_ticks_r))
        else $error("lockout not reloaded after command");
      a_cmd_lock: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cmd_nxt[g] |-> lock_r[g] <= bdms_pkg::lock_t'(1))
        else $error("command issued while locked out");
    end
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_run_chk
      a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        !(rp_r[g] && pp_r[g]))
        else $error("press and release run pending together");
    end
  endgenerate

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !adv |=> $stable(latch_r) && $stable(rp_r) && $stable(pp_r))
    else $error("debounce state changed without an item");

endmodule
